// ===== design/fbmf_pkg.sv =====
// package for the fnv-1a bitmap membership filter: types, constants, hash step
`timescale 1ns / 1ps

package fbmf_pkg;

  // table geometry
  localparam int TABLE_BITS_LOG2 = 16;
  localparam int WORD_SHIFT      = 6;
  localparam int WORD_BITS       = 1 << WORD_SHIFT;

  // key and hash constants
  localparam int          KEY_BYTES  = 20;
  localparam int          KEY_WIDTH  = KEY_BYTES * 8;
  localparam int          HASH_CNT_W = $clog2(KEY_BYTES);
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;

  // request commands; the unused code behaves as a plain test
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TEST   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // input request
  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] key_bytes_0_to_7;
    logic [63:0] key_bytes_8_to_15;
    logic [31:0] key_bytes_16_to_19;
  } in_req_t;

  // result
  typedef struct packed {
    logic [15:0] folded_hash;
    logic        was_present;
  } out_rsp_t;

  // finished hash handed from the hash unit to the table
  typedef struct packed {
    logic [31:0] hash;
    logic [1:0]  command;
  } hash_res_t;

  // table status seen by the hash unit and the top level
  typedef struct packed {
    logic clearing;
    logic take;
  } tbl_status_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_RUN,
    HS_DONE
  } hash_state_e;

  typedef enum logic [1:0] {
    TS_CLEAR,
    TS_IDLE,
    TS_READ,
    TS_MODIFY
  } tbl_state_e;

  // one fnv-1a round: xor in a byte, then multiply by the prime
  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return 32'(x * FNV_PRIME);
  endfunction

endpackage

// ===== design/fbmf_hash.sv =====
// iterative fnv-1a hash unit, one key byte per cycle
`timescale 1ns / 1ps

module fbmf_hash
  import fbmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_req_t   req_i,
  input  logic      take_i,
  output logic      ready_o,
  output logic      valid_o,
  output hash_res_t res_o
);

  localparam logic [HASH_CNT_W-1:0] LastStep = HASH_CNT_W'(KEY_BYTES - 1);

  hash_state_e           state_q, state_d;
  logic [HASH_CNT_W-1:0] cnt_q;
  logic [31:0]           h_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [1:0]            cmd_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      HS_IDLE: begin
        if (start_i) state_d = HS_RUN;
      end
      HS_RUN: begin
        if (cnt_q == LastStep) state_d = HS_DONE;
      end
      HS_DONE: begin
        if (take_i) state_d = start_i ? HS_RUN : HS_IDLE;
      end
      default: state_d = HS_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    ready_o = (state_q == HS_IDLE) || ((state_q == HS_DONE) && take_i);
    valid_o = (state_q == HS_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hash datapath: load key, then consume byte 0 first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= FNV_BASIS;
      key_q <= {req_i.key_bytes_16_to_19, req_i.key_bytes_8_to_15,
                req_i.key_bytes_0_to_7};
      cmd_q <= req_i.command;
      cnt_q <= '0;
    end else if (state_q == HS_RUN) begin
      h_q   <= fnv_step(h_q, key_q[7:0]);
      key_q <= key_q >> 8;
      cnt_q <= cnt_q + HASH_CNT_W'(1);
    end
  end

  assign res_o.hash    = h_q;
  assign res_o.command = cmd_q;

endmodule

// ===== design/fbmf_table.sv =====
// bit table memory with clearing pass, read-modify-write and result register
`timescale 1ns / 1ps

module fbmf_table
  import fbmf_pkg::*;
#(
  parameter int TableBitsLog2 = TABLE_BITS_LOG2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_valid_i,
  input  hash_res_t   hash_res_i,
  output tbl_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_rsp_o
);

  localparam int WordAddrW = TableBitsLog2 - WORD_SHIFT;
  localparam int Depth     = 1 << WordAddrW;
  localparam int OutW      = (TableBitsLog2 < 16) ? TableBitsLog2 : 16;

  tbl_state_e             state_q, state_d;
  logic [WordAddrW-1:0]   clr_q;
  logic [TableBitsLog2-1:0] idx_q;
  logic [1:0]             cmd_q;
  logic [WORD_BITS-1:0]   rdata_q;
  logic                   out_valid_q;
  out_rsp_t               out_rsp_q;

  logic [WORD_BITS-1:0]   mem_q [Depth];

  logic [31:0]              fold_full;
  logic [TableBitsLog2-1:0] fold_idx;
  logic                     take;
  logic [WordAddrW-1:0]     word_addr;
  logic [WORD_SHIFT-1:0]    bit_sel;
  logic [WORD_BITS-1:0]     bit_mask;
  logic                     prior;
  logic                     mem_we;
  logic                     mem_re;
  logic [WordAddrW-1:0]     mem_waddr;
  logic [WORD_BITS-1:0]     mem_wdata;

  // fold the hash to the table index width
  if (TableBitsLog2 < 32) begin : g_fold
    assign fold_full = hash_res_i.hash ^ (hash_res_i.hash >> (32 - TableBitsLog2));
  end else begin : g_nofold
    assign fold_full = hash_res_i.hash;
  end
  assign fold_idx = fold_full[TableBitsLog2-1:0];

  // take a finished hash only when the result register is free
  assign take = (state_q == TS_IDLE) && hash_valid_i && (!out_valid_q || !out_stall_i);

  assign word_addr = idx_q[TableBitsLog2-1:WORD_SHIFT];
  assign bit_sel   = idx_q[WORD_SHIFT-1:0];
  assign bit_mask  = WORD_BITS'(1) << bit_sel;
  assign prior     = |(rdata_q & bit_mask);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_CLEAR: begin
        if (&clr_q) state_d = TS_IDLE;
      end
      TS_IDLE: begin
        if (take) state_d = TS_READ;
      end
      TS_READ:   state_d = TS_MODIFY;
      TS_MODIFY: state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  // memory control and status
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = (state_q == TS_READ);
    mem_waddr = word_addr;
    mem_wdata = rdata_q;
    unique case (state_q)
      TS_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      TS_MODIFY: begin
        unique case (cmd_q)
          CMD_INSERT: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q | bit_mask;
          end
          CMD_REMOVE: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q & ~bit_mask;
          end
          default: mem_we = 1'b0;
        endcase
      end
      default: mem_we = 1'b0;
    endcase
    status_o.clearing = (state_q == TS_CLEAR);
    status_o.take     = take;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[word_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == TS_CLEAR) clr_q <= clr_q + WordAddrW'(1);
      if (state_q == TS_MODIFY) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q <= fold_idx;
      cmd_q <= hash_res_i.command;
    end
    if (state_q == TS_MODIFY) begin
      out_rsp_q.folded_hash <= 16'(idx_q[OutW-1:0]);
      out_rsp_q.was_present <= prior;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== design/fnv1a_bitmap_membership_filter.sv =====
// top level of the fnv-1a bitmap membership filter
//
//   port group   direction  handshake            payload
//   in           request    in_valid_i/in_stall_o   in_req_i  (in_req_t)
//   out          result     out_valid_o/out_stall_i out_rsp_o (out_rsp_t)
//
// a request is hashed one key byte per cycle, then the table word is read
// and written back (TS_READ, then TS_MODIFY); the next request can be taken
// as soon as the table takes the finished hash, so the hash unit works on a
// new key while the table is still busy. after reset the table is cleared
// one word per cycle, 2^(TableBitsLog2-6) words (1024 by default), with in_stall_o high.
// a stalled result holds the table but the next key is still hashed.
`timescale 1ns / 1ps

module fnv1a_bitmap_membership_filter
  import fbmf_pkg::*;
#(
  parameter int TableBitsLog2 = TABLE_BITS_LOG2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic        hash_ready;
  logic        hash_valid;
  logic        hash_start;
  hash_res_t   hash_res;
  tbl_status_t tbl_status;

  // hold requests off while busy hashing or clearing the table
  assign in_stall_o = !hash_ready || tbl_status.clearing;
  assign hash_start = in_valid_i && !in_stall_o;

  fbmf_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .req_i   (in_req_i),
    .take_i  (tbl_status.take),
    .ready_o (hash_ready),
    .valid_o (hash_valid),
    .res_o   (hash_res)
  );

  fbmf_table #(
    .TableBitsLog2 (TableBitsLog2)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hash_valid_i (hash_valid),
    .hash_res_i   (hash_res),
    .status_o     (tbl_status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

// ===== design/fbmf_checker.sv =====
// port-level checks for the membership filter, bound to the top level
`timescale 1ns / 1ps

module fbmf_checker
  import fbmf_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // a taken request keeps the input stalled while its key is hashed
  a_busy_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while hashing");

  a_busy_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##20 in_stall_o)
    else $error("request taken before hash finished");

  // leaving reset the table is being cleared and no result is shown
  a_reset_exit: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("block not clearing after reset");

endmodule

bind fnv1a_bitmap_membership_filter fbmf_checker u_fbmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
